@@ rtl/adler32_checksum_top_assert.svh @@
// ---------------------------------------------------------------------------
// Adler-32 assertion macros
// Shared concurrent assertion wrappers, clocked on clk, reset by rst_n.
// ---------------------------------------------------------------------------
`ifndef ADLER32_CHECKSUM_TOP_ASSERT_SVH
`define ADLER32_CHECKSUM_TOP_ASSERT_SVH

// plain property, disabled in reset
`define ADL32_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ADL32_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/adl32_pkg.sv @@
// ---------------------------------------------------------------------------
// Adler-32 package
// Shared constants and stage transfer types.
// ---------------------------------------------------------------------------
package adl32_pkg;

  localparam logic [15:0] ADLER_MOD  = 16'd65521;
  // 2^16 mod 65521
  localparam logic [3:0]  ADLER_FOLD = 4'd15;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 3;   // byte count field, at most 7 bytes counted
  localparam int PROD_W = 11;  // weight (<= 7) times byte
  localparam int S_W    = 11;  // plain byte sum, <= 7*255
  localparam int W_W    = 13;  // weighted byte sum, <= 28*255

  // register index decode (paddr[2])
  localparam logic REG_SEED_LOW  = 1'b0;
  localparam logic REG_SEED_HIGH = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0] nbytes;
    logic             restart;
    logic             last;
  } adl32_ctl_t;

  typedef struct packed {
    adl32_ctl_t     ctl;
    logic [S_W-1:0] sum_bytes;
    logic [W_W-1:0] sum_wtd;
  } adl32_item_t;

endpackage

@@ rtl/adler32_checksum_top.sv @@
// ---------------------------------------------------------------------------
// Adler-32 checksum top level
// Running Adler-32 over a byte stream, up to LANES bytes per transfer.
// ---------------------------------------------------------------------------
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------
//  input   | in_data_word, in_byte_count, in_restart,| in_valid / in_ready
//          | in_last                                 |
//  result  | out_checksum, out_final_res             | out_valid / out_ready
//  config  | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
//  Sustained rate is one transfer per cycle while out_ready holds high; the
//  path runs through the lane register, merge register and result register.
//  The sums update in the accumulate stage: n*A plus a 16-bit fold and one
//  compare-subtract close the loop.
//  Reset clears the seeds, both sums and all stage valids; no clearing pass.
//  Each stage advances when the stage after it is empty or drains, so the
//  block keeps taking transfers while a result waits, until the pipe fills.
//
// ---------------------------------------------------------------------------
module adler32_checksum_top #(
  parameter int LANES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_restart,
  input  logic        in_last,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_checksum,
  output logic        out_final_res,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DATA_BYTES = 4;

  // seed registers, kept raw and reduced on the way to the accumulator
  logic [15:0] seed_lo_r, seed_lo_nxt;
  logic [15:0] seed_hi_r, seed_hi_nxt;
  logic [15:0] seed_lo_red, seed_hi_red;
  logic        cfg_wr;

  // stage 1: lane registers plus control
  logic                    s1_valid_r, s1_valid_nxt;
  adl32_pkg::adl32_ctl_t   s1_ctl_r, s1_ctl_nxt;
  logic                    s1_load;
  logic [adl32_pkg::CNT_W-1:0] n_sat;
  logic [LANES-1:0][adl32_pkg::BYTE_W-1:0] lane_in;
  logic [LANES-1:0][adl32_pkg::BYTE_W-1:0] lane_byte;
  logic [LANES-1:0][adl32_pkg::PROD_W-1:0] lane_wtd;

  // stage 2: merged item
  logic                    s2_ready;
  logic                    s2_valid;
  adl32_pkg::adl32_item_t  s2_item;
  logic                    acc_ready;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    seed_lo_nxt = seed_lo_r;
    seed_hi_nxt = seed_hi_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        adl32_pkg::REG_SEED_LOW:  seed_lo_nxt = pwdata[15:0];
        adl32_pkg::REG_SEED_HIGH: seed_hi_nxt = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      adl32_pkg::REG_SEED_LOW:  prdata = 32'(seed_lo_r);
      adl32_pkg::REG_SEED_HIGH: prdata = 32'(seed_hi_r);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_lo_r <= '0;
      seed_hi_r <= '0;
    end else begin
      seed_lo_r <= seed_lo_nxt;
      seed_hi_r <= seed_hi_nxt;
    end
  end

  // a raw seed is below 2*65521, so one subtract reduces it
  assign seed_lo_red = (seed_lo_r >= adl32_pkg::ADLER_MOD) ?
                       seed_lo_r - adl32_pkg::ADLER_MOD : seed_lo_r;
  assign seed_hi_red = (seed_hi_r >= adl32_pkg::ADLER_MOD) ?
                       seed_hi_r - adl32_pkg::ADLER_MOD : seed_hi_r;

  // ---------------- stage 1: lanes ----------------
  assign in_ready = !s1_valid_r || s2_ready;
  assign s1_load  = in_ready && in_valid;

  always_comb begin
    // count saturates at the lane count
    n_sat = (32'(in_byte_count) > LANES) ? adl32_pkg::CNT_W'(LANES) : in_byte_count;
    s1_ctl_nxt.nbytes  = n_sat;
    s1_ctl_nxt.restart = in_restart;
    s1_ctl_nxt.last    = in_last;
    s1_valid_nxt       = in_ready ? in_valid : s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    // lanes past the data word see zero but still count
    if (i < DATA_BYTES) begin : g_data
      assign lane_in[i] = in_data_word[i*adl32_pkg::BYTE_W +: adl32_pkg::BYTE_W];
    end else begin : g_zero
      assign lane_in[i] = '0;
    end

    adl32_lane #(
      .LANE_IDX (i)
    ) u_lane (
      .clk     (clk),
      .load    (s1_load),
      .byte_in (lane_in[i]),
      .nbytes  (n_sat),
      .byte_r  (lane_byte[i]),
      .wtd_r   (lane_wtd[i])
    );
  end

  // ---------------- stage 2: merge ----------------
  adl32_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s1_valid_r),
    .in_rdy    (s2_ready),
    .in_ctl    (s1_ctl_r),
    .lane_byte (lane_byte),
    .lane_wtd  (lane_wtd),
    .out_vld_r (s2_valid),
    .out_rdy   (acc_ready),
    .item_r    (s2_item)
  );

  // ---------------- stage 3: accumulate and result ----------------
  adl32_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (s2_valid),
    .in_rdy     (acc_ready),
    .item       (s2_item),
    .seed_a     (seed_lo_red),
    .seed_b     (seed_hi_red),
    .out_vld_r  (out_valid),
    .out_rdy    (out_ready),
    .checksum_r (out_checksum),
    .final_r    (out_final_res)
  );

endmodule

@@ rtl/adl32_lane.sv @@
// ---------------------------------------------------------------------------
// Adler-32 byte lane
// Masks one byte by the valid count and forms its weighted contribution.
// ---------------------------------------------------------------------------
module adl32_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic                              clk,
  input  logic                              load,
  input  logic [adl32_pkg::BYTE_W-1:0]      byte_in,
  input  logic [adl32_pkg::CNT_W-1:0]       nbytes,
  output logic [adl32_pkg::BYTE_W-1:0]      byte_r,
  output logic [adl32_pkg::PROD_W-1:0]      wtd_r
);

  logic                               lane_en;
  logic [adl32_pkg::CNT_W-1:0]        weight;
  logic [adl32_pkg::BYTE_W-1:0]       byte_nxt;
  logic [adl32_pkg::PROD_W-1:0]       wtd_nxt;

  // byte i is added n-i times into sum B
  always_comb begin
    lane_en  = (32'(nbytes) > LANE_IDX);
    weight   = nbytes - adl32_pkg::CNT_W'(LANE_IDX);
    byte_nxt = lane_en ? byte_in : '0;
    wtd_nxt  = lane_en ? adl32_pkg::PROD_W'(weight) * adl32_pkg::PROD_W'(byte_in) : '0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      wtd_r  <= wtd_nxt;
    end
  end

endmodule

@@ rtl/adl32_merge.sv @@
// ---------------------------------------------------------------------------
// Adler-32 lane merge
// Adds the lane contributions into the plain and weighted byte sums.
// ---------------------------------------------------------------------------
module adl32_merge #(
  parameter int LANES = 4
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_vld,
  output logic                                         in_rdy,
  input  adl32_pkg::adl32_ctl_t                        in_ctl,
  input  logic [LANES-1:0][adl32_pkg::BYTE_W-1:0]      lane_byte,
  input  logic [LANES-1:0][adl32_pkg::PROD_W-1:0]      lane_wtd,
  output logic                                         out_vld_r,
  input  logic                                         out_rdy,
  output adl32_pkg::adl32_item_t                       item_r
);

  logic                          out_vld_nxt;
  adl32_pkg::adl32_item_t        item_nxt;
  logic [adl32_pkg::S_W-1:0]     s_acc;
  logic [adl32_pkg::W_W-1:0]     w_acc;

  assign in_rdy = !out_vld_r || out_rdy;

  always_comb begin
    s_acc = '0;
    w_acc = '0;
    for (int i = 0; i < LANES; i++) begin
      s_acc = s_acc + adl32_pkg::S_W'(lane_byte[i]);
      w_acc = w_acc + adl32_pkg::W_W'(lane_wtd[i]);
    end
    item_nxt.ctl       = in_ctl;
    item_nxt.sum_bytes = s_acc;
    item_nxt.sum_wtd   = w_acc;
    out_vld_nxt        = in_rdy ? in_vld : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ rtl/adl32_accum.sv @@
// ---------------------------------------------------------------------------
// Adler-32 accumulator
// Folds one merged item into sums A and B and holds the result register.
// ---------------------------------------------------------------------------
module adl32_accum (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  output logic                     in_rdy,
  input  adl32_pkg::adl32_item_t   item,
  input  logic [15:0]              seed_a,
  input  logic [15:0]              seed_b,
  output logic                     out_vld_r,
  input  logic                     out_rdy,
  output logic [31:0]              checksum_r,
  output logic                     final_r
);

  logic        load;
  logic [15:0] sum_a_r, sum_a_nxt;
  logic [15:0] sum_b_r, sum_b_nxt;
  logic        out_vld_nxt;
  logic [15:0] a0, b0;
  logic [16:0] a_sum;
  logic [19:0] b_sum;
  logic [16:0] b_fold;

  assign in_rdy = !out_vld_r || out_rdy;
  assign load   = in_rdy && in_vld;

  // A' = A + S, B' = B + n*A + W, both mod 65521
  always_comb begin
    a0     = item.ctl.restart ? seed_a : sum_a_r;
    b0     = item.ctl.restart ? seed_b : sum_b_r;
    a_sum  = 17'(a0) + 17'(item.sum_bytes);
    b_sum  = 20'(b0) + 20'(a0) * 20'(item.ctl.nbytes) + 20'(item.sum_wtd);
    b_fold = 17'(b_sum[15:0]) + 17'(b_sum[19:16]) * 17'(adl32_pkg::ADLER_FOLD);
    sum_a_nxt = (a_sum >= 17'(adl32_pkg::ADLER_MOD)) ?
                16'(a_sum - 17'(adl32_pkg::ADLER_MOD)) : a_sum[15:0];
    sum_b_nxt = (b_fold >= 17'(adl32_pkg::ADLER_MOD)) ?
                16'(b_fold - 17'(adl32_pkg::ADLER_MOD)) : b_fold[15:0];
    out_vld_nxt = in_rdy ? in_vld : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sum_a_r   <= '0;
      sum_b_r   <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (load) begin
        sum_a_r <= sum_a_nxt;
        sum_b_r <= sum_b_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      checksum_r <= {sum_b_nxt, sum_a_nxt};
      final_r    <= item.ctl.last;
    end
  end

`include "adler32_checksum_top_assert.svh"

`ADL32_ASSERT(a_sum_in_range, (sum_a_r < adl32_pkg::ADLER_MOD), "sum A out of range")
`ADL32_ASSERT(b_sum_in_range, (sum_b_r < adl32_pkg::ADLER_MOD), "sum B out of range")
`ADL32_ASSERT(result_tracks_sums, (!out_vld_r || (checksum_r == {sum_b_r, sum_a_r})), "result differs from sums")
`ADL32_ASSERT_NEXT(empty_item_keeps_sums, (load && (item.ctl.nbytes == '0) && !item.ctl.restart), ($stable(sum_a_r) && $stable(sum_b_r)), "empty item changed sums")

endmodule
